@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker sdcd_chk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, clocked on clk, off while arst_n is low
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/sdcd_pkg.sv @@
// ----------------------------------------------------------------------------
// sdcd_pkg
// Types, constants and helpers for the SD clock divider setup block.
// ----------------------------------------------------------------------------
package sdcd_pkg;

	localparam int FREQ_W = 28;
	localparam int OFFS_W = 12;
	localparam int SRC_W  = 30;
	localparam int WORD_W = 32;
	localparam int MUL_W  = 5;
	localparam int PDIV_W = 2;
	localparam int BASE_W = 25;

	localparam int DIV_STEPS = SRC_W / 2;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [FREQ_W-1:0] OSC_HZ    = 28'd24000000;
	localparam logic [FREQ_W-1:0] BAND_SLOW = 28'd400000;
	localparam logic [FREQ_W-1:0] BAND_MID  = 28'd25000000;
	localparam logic [FREQ_W-1:0] BAND_FAST = 28'd52000000;
	localparam logic [SRC_W-1:0]  DIV_MAX   = 30'd16;
	localparam logic [1:0]        PREDIV_MAX = 2'd3;

	localparam logic [MUL_W-1:0]  MUL_RESET  = 5'd24;
	localparam logic [PDIV_W-1:0] PDIV_RESET = 2'd0;

	typedef struct packed {
		logic [FREQ_W-1:0] requested_freq;
		logic [OFFS_W-1:0] target_offset;
	} in_t;

	typedef struct packed {
		logic              ok;
		logic [WORD_W-1:0] clock_word;
		logic [SRC_W-1:0]  achieved_freq;
		logic [OFFS_W-1:0] offset_out;
	} out_t;

	typedef enum logic [0:0] {
		CFG_PLL_MUL = 1'b0,
		CFG_PLL_DIV = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRC,
		S_DIV1,
		S_HALVE,
		S_DIV2,
		S_OUT
	} state_t;

	typedef enum logic [0:0] {
		DIV_BY_FREQ,
		DIV_BY_DV
	} div_sel_t;

	typedef struct packed {
		logic     capture;
		logic     load_src;
		logic     div_go;
		div_sel_t div_sel;
		logic     load_dv;
		logic     halve;
		logic     load_ok;
		logic     load_fail;
	} cmd_t;

	typedef struct packed {
		logic zero;
		logic div_done;
		logic dv_big;
		logic pre_max;
	} sts_t;

	// PLL rate per unit of multiplier: 24 MHz over (div + 1), exact
	function automatic logic [BASE_W-1:0] pll_base(input logic [PDIV_W-1:0] d);
		logic [BASE_W-1:0] b;
		case (d)
			2'd0: b = 25'd24000000;
			2'd1: b = 25'd12000000;
			2'd2: b = 25'd8000000;
			default: b = 25'd6000000;
		endcase
		return b;
	endfunction

endpackage

@@ rtl/sdcd_div.sv @@
// ----------------------------------------------------------------------------
// sdcd_div
// Restoring divider, two quotient bits per cycle, shared by both divisions.
// ----------------------------------------------------------------------------
module sdcd_div
	import sdcd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [SRC_W-1:0] dividend,
	input  logic [SRC_W-1:0] divisor,
	output logic [SRC_W-1:0] quo,
	output logic             rem_nz,
	output logic             done
);

	logic [SRC_W-1:0]     quo_q;
	logic [SRC_W-1:0]     rem_q;
	logic [SRC_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;

	logic [SRC_W:0]   r1, r2;
	logic             ge1, ge2;
	logic [SRC_W-1:0] r1n, r2n;

	always_comb begin
		r1  = {rem_q, quo_q[SRC_W-1]};
		ge1 = r1 >= {1'b0, dvs_q};
		r1n = ge1 ? SRC_W'(r1 - {1'b0, dvs_q}) : r1[SRC_W-1:0];
		r2  = {r1n, quo_q[SRC_W-2]};
		ge2 = r2 >= {1'b0, dvs_q};
		r2n = ge2 ? SRC_W'(r2 - {1'b0, dvs_q}) : r2[SRC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[SRC_W-3:0], ge1, ge2};
			rem_q <= r2n;
		end
	end

	assign quo    = quo_q;
	assign rem_nz = |rem_q;
	assign done   = done_q;

endmodule

@@ rtl/sdcd_dp.sv @@
// ----------------------------------------------------------------------------
// sdcd_dp
// Datapath: PLL registers, source rate, divider, halving and word packing.
// ----------------------------------------------------------------------------
module sdcd_dp
	import sdcd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  cfg_idx_t          cfg_index,
	input  logic [MUL_W-1:0]  cfg_data,
	input  in_t               req,
	input  cmd_t              cmd,
	output sts_t              sts,
	output out_t              res
);

	logic [MUL_W-1:0]  mul_q;
	logic [PDIV_W-1:0] pdiv_q;
	logic [FREQ_W-1:0] freq_q;
	logic [OFFS_W-1:0] offs_q;
	logic              pll_q;
	logic [SRC_W-1:0]  src_q;
	logic [SRC_W-1:0]  dv_q;
	logic [1:0]        pre_q;
	out_t              res_q;

	logic [MUL_W:0]    mul_p1;
	logic [SRC_W:0]    prod;
	logic [SRC_W-1:0]  src_d;
	logic [SRC_W-1:0]  dvd;
	logic [SRC_W-1:0]  dvs;
	logic [SRC_W-1:0]  quo;
	logic              rem_nz;
	logic              div_done;
	logic [SRC_W:0]    dv_inc;
	logic [SRC_W-1:0]  dv_m1;
	logic [2:0]        samp;
	logic [2:0]        outp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q  <= MUL_RESET;
			pdiv_q <= PDIV_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PLL_MUL: mul_q  <= cfg_data;
				CFG_PLL_DIV: pdiv_q <= cfg_data[PDIV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		mul_p1 = {1'b0, mul_q} + 1'b1;
		prod   = (SRC_W+1)'(mul_p1) * (SRC_W+1)'(pll_base(pdiv_q));
		src_d  = pll_q ? prod[SRC_W-1:0] : SRC_W'(OSC_HZ);
		dvd    = (cmd.div_sel == DIV_BY_DV) ? src_q : src_d;
		dvs    = (cmd.div_sel == DIV_BY_DV) ? dv_q : SRC_W'(freq_q);
		dv_inc = {1'b0, dv_q} + 1'b1;
		dv_m1  = dv_q - 1'b1;
		if (freq_q <= BAND_SLOW) begin
			outp = 3'd0; samp = 3'd0;
		end else if (freq_q <= BAND_MID) begin
			outp = 3'd0; samp = 3'd5;
		end else if (freq_q <= BAND_FAST) begin
			outp = 3'd3; samp = 3'd4;
		end else begin
			outp = 3'd1; samp = 3'd4;
		end
	end

	sdcd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (dvd),
		.divisor  (dvs),
		.quo      (quo),
		.rem_nz   (rem_nz),
		.done     (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			freq_q <= req.requested_freq;
			offs_q <= req.target_offset;
			pll_q  <= req.requested_freq > OSC_HZ;
			pre_q  <= '0;
		end
		if (cmd.load_src)
			src_q <= src_d;
		if (cmd.load_dv)
			dv_q <= quo + SRC_W'(rem_nz);
		if (cmd.halve) begin
			dv_q  <= dv_inc[SRC_W:1];
			pre_q <= pre_q + 1'b1;
		end
		if (cmd.load_ok) begin
			res_q.ok            <= 1'b1;
			res_q.clock_word    <= {1'b1, 6'b0, pll_q, 1'b0, samp, 2'b0, pre_q,
				5'b0, outp, 4'b0, dv_m1[3:0]};
			res_q.achieved_freq <= quo >> pre_q;
			res_q.offset_out    <= offs_q;
		end
		if (cmd.load_fail) begin
			res_q.ok            <= 1'b0;
			res_q.clock_word    <= '0;
			res_q.achieved_freq <= '0;
			res_q.offset_out    <= offs_q;
		end
	end

	assign sts.zero     = freq_q == '0;
	assign sts.div_done = div_done;
	assign sts.dv_big   = dv_q > DIV_MAX;
	assign sts.pre_max  = pre_q == PREDIV_MAX;
	assign res          = res_q;

endmodule

@@ rtl/sdcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// sdcd_ctrl
// Controller: sequences source, division, halving and result load.
// ----------------------------------------------------------------------------
module sdcd_ctrl
	import sdcd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic done
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_SRC;
				end
			end
			S_SRC: begin
				if (sts.zero) begin
					cmd.load_fail = 1'b1;
					state_d       = S_OUT;
				end else begin
					cmd.load_src = 1'b1;
					cmd.div_go   = 1'b1;
					cmd.div_sel  = DIV_BY_FREQ;
					state_d      = S_DIV1;
				end
			end
			S_DIV1: begin
				if (sts.div_done) begin
					cmd.load_dv = 1'b1;
					state_d     = S_HALVE;
				end
			end
			S_HALVE: begin
				if (!sts.dv_big) begin
					cmd.div_go  = 1'b1;
					cmd.div_sel = DIV_BY_DV;
					state_d     = S_DIV2;
				end else if (sts.pre_max) begin
					cmd.load_fail = 1'b1;
					state_d       = S_OUT;
				end else begin
					cmd.halve = 1'b1;
				end
			end
			S_DIV2: begin
				if (sts.div_done) begin
					cmd.load_ok = 1'b1;
					state_d     = S_OUT;
				end
			end
			S_OUT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_OUT;

endmodule

@@ rtl/sd_clock_divider_setup.sv @@
// ----------------------------------------------------------------------------
// sd_clock_divider_setup
// SD card clock divider setup: request in, clock register word out.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req and raise start; the beat is taken at a rising
//   edge with start high and busy low. busy stays high until the result.
//   Result channel: done is high for exactly one cycle with res valid.
//   The receiver cannot stall; sample res on the done cycle.
//   Config channel: cfg_valid with cfg_index and cfg_data; cfg_ready is
//   always high. Index 0 is the PLL multiplier, index 1 the PLL divider.
//   Write only while busy is low.
// Sequence: a zero request fails straight from the source step, a divider
//   that needs a fourth halving fails after the first division. Otherwise:
//   source, two passes of the 2-bit-per-cycle divider, zero to three
//   halvings, output. One request at a time; the next is taken after done.
// Reset: arst_n low clears the sequencer and loads PLL multiplier 24 and
//   divider 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sd_clock_divider_setup
	import sdcd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  in_t              req,
	output logic             done,
	output out_t             res,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  cfg_idx_t         cfg_index,
	input  logic [MUL_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;
	logic busy_w;

	assign cfg_ready = 1'b1;
	assign busy      = busy_w;

	sdcd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy_w),
		.done   (done)
	);

	sdcd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res)
	);

endmodule

@@ rtl/sdcd_chk.sv @@
// ----------------------------------------------------------------------------
// sdcd_chk
// Port-level checker for the SD clock divider setup block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdcd_chk
	import sdcd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input out_t res
);

	`ASSERT_IMPL(a_done_busy, done, busy)
	`ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`ASSERT_NEXT(a_done_pulse, done, !done)
	`ASSERT_IMPL(a_fail_zero, done && !res.ok, res.clock_word == '0 && res.achieved_freq == '0)
	`ASSERT_IMPL(a_ok_enable, done && res.ok, res.clock_word[31])

endmodule

bind sd_clock_divider_setup sdcd_chk u_chk (.*);
